// ===== hdl/pss_pkg.sv =====
// Shared types, constants and helpers of the sand particle step core.
`default_nettype none

package pss_pkg;

  localparam int PSS_PARTICLE_COUNT = 1024;
  localparam int PSS_SCREEN_WIDTH   = 64;
  localparam int PSS_SCREEN_HEIGHT  = 128;

  // Q24 fixed point: pixels * 2^24
  localparam int FRAC_W      = 24;
  localparam int POS_W       = 32;
  localparam int SPD_W       = 32;
  localparam int ACC_W       = 25;
  localparam int WIDE_W      = 44;
  localparam int GAIN_SHIFT  = 16;
  localparam int ELAST_SHIFT = 8;

  localparam logic signed [POS_W-1:0] POS_X_INIT = 32'sd536870912;  // 32.0
  localparam logic signed [POS_W-1:0] POS_Y_INIT = 32'sd167772160;  // 10.0
  localparam logic signed [19:0]      NOISE_SCALE = 20'sd1678;
  localparam logic signed [WIDE_W-1:0] SPEED_LIMIT = 44'sd2130706432;  // 127.0

  localparam logic [23:0] GAIN_INIT  = 24'd5497558;
  localparam logic [8:0]  ELAST_INIT = 9'd51;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_STEP   = 2'd1,
    ACT_PIX_WR = 2'd2,
    ACT_PIX_RD = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_REF_X = 2'd0,
    REG_REF_Y = 2'd1,
    REG_GAIN  = 2'd2,
    REG_ELAST = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [SPD_W-1:0] sx;
    logic [SPD_W-1:0] sy;
  } particle_t;

  function automatic logic signed [SPD_W-1:0] sat_speed(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    r = v;
    if (v > SPEED_LIMIT) begin
      r = SPEED_LIMIT;
    end else if (v < -SPEED_LIMIT) begin
      r = -SPEED_LIMIT;
    end
    return SPD_W'(r);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pixel_sand_particle_step_core.sv =====
// Sand particle step core: particle and occupancy memories with read-modify-write control.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-------------------------------------------
//  command   | start_i, busy_o                | action_i, sample_*_i, particle_i, noise_*_i,
//            |                                | pixel_col_i, pixel_row_i, pixel_set_i
//  config    | cfg_valid_i, cfg_ready_o       | cfg_index_i, cfg_data_i
//  result    | result_valid_o (one cycle)     | old/new col/row, moved_*, bounced_*, pixel_value
//
// A particle step keeps busy_o high through the load, x axis, y axis and write back states;
// the occupancy memory has a single write port. A sample works the two axes in turn on one
// shared multiplier, a pixel access reads the row and, for a write, writes it back, and a step
// of an out-of-range particle gives its result without raising busy_o. After reset a clearing
// pass initializes both memories with busy_o high.
// Configuration writes are taken in any cycle. The result strobe cannot be held off.
`default_nettype none

module pixel_sand_particle_step_core #(
  parameter int PARTICLE_COUNT = pss_pkg::PSS_PARTICLE_COUNT,
  parameter int SCREEN_WIDTH   = pss_pkg::PSS_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT  = pss_pkg::PSS_SCREEN_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         action_i,
  input  logic signed [15:0] sample_x_i,
  input  logic signed [15:0] sample_y_i,
  input  logic [9:0]         particle_i,
  input  logic signed [7:0]  noise_x_i,
  input  logic signed [7:0]  noise_y_i,
  input  logic [5:0]         pixel_col_i,
  input  logic [6:0]         pixel_row_i,
  input  logic               pixel_set_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [5:0]         old_col_o,
  output logic [6:0]         old_row_o,
  output logic [5:0]         new_col_o,
  output logic [6:0]         new_row_o,
  output logic               moved_col_o,
  output logic               moved_row_o,
  output logic               bounced_col_o,
  output logic               bounced_row_o,
  output logic               pixel_value_o
);

  import pss_pkg::*;

  localparam int PIDX_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int CLR_N  = (PARTICLE_COUNT > SCREEN_HEIGHT) ? PARTICLE_COUNT : SCREEN_HEIGHT;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam int CRD_W  = 9;  // pixel coordinate with sign and overflow room

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_ACCX = 4'd2;
  localparam logic [3:0] ST_ACCY = 4'd3;
  localparam logic [3:0] ST_PIXW = 4'd4;
  localparam logic [3:0] ST_PIXR = 4'd5;
  localparam logic [3:0] ST_LOAD = 4'd6;
  localparam logic [3:0] ST_XAX  = 4'd7;
  localparam logic [3:0] ST_YAX  = 4'd8;
  localparam logic [3:0] ST_WB   = 4'd9;

  function automatic logic col_on(input logic signed [CRD_W-1:0] c);
    return (c >= 0) && (c < SCREEN_WIDTH);
  endfunction

  function automatic logic row_on(input logic signed [CRD_W-1:0] r);
    return (r >= 0) && (r < SCREEN_HEIGHT);
  endfunction

  // control state
  logic [3:0]              state_q, state_d;
  logic [CLR_W-1:0]        clr_cnt_q, clr_cnt_d;
  logic signed [15:0]      ref_x_q, ref_x_d, ref_y_q, ref_y_d;
  logic [23:0]             gain_q, gain_d;
  logic [8:0]              elast_q, elast_d;
  logic signed [ACC_W-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic                    res_vld_q, res_vld_d;

  // item payload
  logic signed [15:0]      smp_x_q, smp_x_d, smp_y_q, smp_y_d;
  logic [PIDX_W-1:0]       pid_q, pid_d;
  logic signed [7:0]       nz_x_q, nz_x_d, nz_y_q, nz_y_d;
  logic [5:0]              pcol_q, pcol_d;
  logic [6:0]              prow_q, prow_d;
  logic                    pset_q, pset_d, pix_ok_q, pix_ok_d;
  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d, pysum_q, pysum_d;
  logic signed [SPD_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [CRD_W-1:0] c1_q, c1_d, r1_q, r1_d, c1n_q, c1n_d, r2_q, r2_d;
  logic [SCREEN_WIDTH-1:0] rowa_q, rowa_d, rowb_q, rowb_d;
  logic                    rowb_we_q, rowb_we_d;
  logic signed [42:0]      bprod_q, bprod_d;
  logic                    mc_q, mc_d, mr_q, mr_d, bc_q, bc_d, br_q, br_d;

  // result registers
  logic [5:0] res_oc_q, res_oc_d, res_nc_q, res_nc_d;
  logic [6:0] res_or_q, res_or_d, res_nr_q, res_nr_d;
  logic       res_mc_q, res_mc_d, res_mr_q, res_mr_d;
  logic       res_bc_q, res_bc_d, res_br_q, res_br_d, res_pv_q, res_pv_d;

  // memories
  particle_t               pm_mem [PARTICLE_COUNT];
  particle_t               pm_rd_q, pm_wdata;
  logic                    pm_re, pm_we;
  logic [PIDX_W-1:0]       pm_waddr;
  logic [SCREEN_WIDTH-1:0] occ_mem [SCREEN_HEIGHT];
  logic [SCREEN_WIDTH-1:0] occ_rd_q, occ_wdata;
  logic                    occ_re, occ_we;
  logic [ROW_W-1:0]        occ_raddr, occ_waddr;

  // datapath
  logic                    accept, pid_ok;
  logic signed [19:0]      nzx_term, nzy_term;
  logic signed [WIDE_W-1:0] ld_sumx, ld_sumy;
  logic signed [POS_W-1:0] ld_px, ld_py;
  logic signed [CRD_W-1:0] ld_c1, ld_r1, c2, r2y;
  logic signed [POS_W:0]   xsum, ysum;
  logic signed [16:0]      am_d;
  logic signed [24:0]      am_g;
  logic signed [41:0]      am_prod;
  logic signed [SPD_W-1:0] bm_s, bounce_v;
  logic signed [32:0]      bm_neg;
  logic signed [9:0]       bm_e;
  logic signed [42:0]      bm_prod;
  logic [SCREEN_WIDTH-1:0] row_x, row_y, row_b, row_p;

  assign accept = start_i && !busy_o;
  assign pid_ok = int'(particle_i) < PARTICLE_COUNT;
  assign pm_re  = accept && (action_i == ACT_STEP) && pid_ok;

  // speed update from the loaded particle
  assign ld_px    = $signed(pm_rd_q.px);
  assign ld_py    = $signed(pm_rd_q.py);
  assign nzx_term = 20'(nz_x_q) * NOISE_SCALE;
  assign nzy_term = 20'(nz_y_q) * NOISE_SCALE;
  assign ld_sumx  = WIDE_W'($signed(pm_rd_q.sx)) + WIDE_W'(acc_x_q) + WIDE_W'(nzx_term);
  assign ld_sumy  = WIDE_W'($signed(pm_rd_q.sy)) + WIDE_W'(acc_y_q) + WIDE_W'(nzy_term);
  assign ld_c1    = CRD_W'(ld_px >>> FRAC_W);
  assign ld_r1    = CRD_W'(ld_py >>> FRAC_W);

  // target pixels
  assign xsum = (POS_W + 1)'(px_q) + (POS_W + 1)'(sx_q);
  assign ysum = (POS_W + 1)'(py_q) + (POS_W + 1)'(sy_q);
  assign c2   = CRD_W'(xsum >>> FRAC_W);
  assign r2y  = CRD_W'(ysum >>> FRAC_W);

  // shared acceleration multiplier
  assign am_d    = (state_q == ST_ACCX) ? (17'(smp_x_q) - 17'(ref_x_q))
                                        : (17'(smp_y_q) - 17'(ref_y_q));
  assign am_g    = $signed({1'b0, gain_q});
  assign am_prod = am_d * am_g;

  // shared bounce multiplier: x axis in ST_XAX, y axis in ST_YAX
  assign bm_s     = (state_q == ST_XAX) ? sx_q : sy_q;
  assign bm_neg   = -(33'(bm_s));
  assign bm_e     = $signed({1'b0, elast_q});
  assign bm_prod  = bm_neg * bm_e;
  assign bounce_v = sat_speed(WIDE_W'(bprod_q >>> ELAST_SHIFT));

  // row edits
  always_comb begin
    row_x = occ_rd_q;
    if (col_on(c1_q)) begin
      row_x[COL_W'(c1_q)] = 1'b0;
    end
    if (col_on(c2)) begin
      row_x[COL_W'(c2)] = 1'b1;
    end
    row_y = rowa_q;
    row_b = occ_rd_q;
    if (col_on(c1n_q)) begin
      row_y[COL_W'(c1n_q)] = 1'b0;
      row_b[COL_W'(c1n_q)] = 1'b1;
    end
    row_p = occ_rd_q;
    if (pix_ok_q) begin
      row_p[COL_W'(pcol_q)] = pset_q;
    end
  end

  // configuration
  always_comb begin
    ref_x_d = ref_x_q;
    ref_y_d = ref_y_q;
    gain_d  = gain_q;
    elast_d = elast_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_REF_X: ref_x_d = cfg_data_i[15:0];
        REG_REF_Y: ref_y_d = cfg_data_i[15:0];
        REG_GAIN:  gain_d  = cfg_data_i;
        REG_ELAST: elast_d = cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    acc_x_d   = acc_x_q;
    acc_y_d   = acc_y_q;
    res_vld_d = 1'b0;
    smp_x_d   = smp_x_q;
    smp_y_d   = smp_y_q;
    pid_d     = pid_q;
    nz_x_d    = nz_x_q;
    nz_y_d    = nz_y_q;
    pcol_d    = pcol_q;
    prow_d    = prow_q;
    pset_d    = pset_q;
    pix_ok_d  = pix_ok_q;
    px_d      = px_q;
    py_d      = py_q;
    pysum_d   = pysum_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    c1_d      = c1_q;
    r1_d      = r1_q;
    c1n_d     = c1n_q;
    r2_d      = r2_q;
    rowa_d    = rowa_q;
    rowb_d    = rowb_q;
    rowb_we_d = rowb_we_q;
    bprod_d   = bprod_q;
    mc_d      = mc_q;
    mr_d      = mr_q;
    bc_d      = bc_q;
    br_d      = br_q;
    res_oc_d  = '0;
    res_or_d  = '0;
    res_nc_d  = '0;
    res_nr_d  = '0;
    res_mc_d  = 1'b0;
    res_mr_d  = 1'b0;
    res_bc_d  = 1'b0;
    res_br_d  = 1'b0;
    res_pv_d  = 1'b0;
    occ_re    = 1'b0;
    occ_raddr = '0;
    occ_we    = 1'b0;
    occ_waddr = '0;
    occ_wdata = '0;
    pm_we     = 1'b0;
    pm_waddr  = '0;
    pm_wdata  = '0;

    case (state_q)
      ST_CLR: begin
        if (int'(clr_cnt_q) < PARTICLE_COUNT) begin
          pm_we    = 1'b1;
          pm_waddr = PIDX_W'(clr_cnt_q);
          pm_wdata = '{px: POS_X_INIT, py: POS_Y_INIT, sx: '0, sy: '0};
        end
        if (int'(clr_cnt_q) < SCREEN_HEIGHT) begin
          occ_we    = 1'b1;
          occ_waddr = ROW_W'(clr_cnt_q);
        end
        if (clr_cnt_q == CLR_W'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          smp_x_d  = sample_x_i;
          smp_y_d  = sample_y_i;
          pid_d    = PIDX_W'(particle_i);
          nz_x_d   = noise_x_i;
          nz_y_d   = noise_y_i;
          pcol_d   = pixel_col_i;
          prow_d   = pixel_row_i;
          pset_d   = pixel_set_i;
          pix_ok_d = (int'(pixel_col_i) < SCREEN_WIDTH) && (int'(pixel_row_i) < SCREEN_HEIGHT);
          case (action_e'(action_i))
            ACT_SAMPLE: state_d = ST_ACCX;
            ACT_STEP: begin
              if (pid_ok) begin
                state_d = ST_LOAD;
              end else begin
                res_vld_d = 1'b1;
              end
            end
            ACT_PIX_WR: begin
              occ_re    = 1'b1;
              occ_raddr = ROW_W'(pixel_row_i);
              state_d   = ST_PIXW;
            end
            ACT_PIX_RD: begin
              occ_re    = 1'b1;
              occ_raddr = ROW_W'(pixel_row_i);
              state_d   = ST_PIXR;
            end
            default: ;
          endcase
        end
      end

      ST_ACCX: begin
        acc_x_d = am_prod[GAIN_SHIFT+ACC_W-1:GAIN_SHIFT];
        state_d = ST_ACCY;
      end

      ST_ACCY: begin
        acc_y_d   = am_prod[GAIN_SHIFT+ACC_W-1:GAIN_SHIFT];
        res_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end

      ST_PIXW: begin
        if (pix_ok_q) begin
          occ_we    = 1'b1;
          occ_waddr = ROW_W'(prow_q);
          occ_wdata = row_p;
        end
        res_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end

      ST_PIXR: begin
        res_pv_d  = pix_ok_q && occ_rd_q[COL_W'(pcol_q)];
        res_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end

      ST_LOAD: begin
        px_d      = ld_px;
        py_d      = ld_py;
        sx_d      = sat_speed(ld_sumx);
        sy_d      = sat_speed(ld_sumy);
        c1_d      = ld_c1;
        r1_d      = ld_r1;
        mc_d      = 1'b0;
        mr_d      = 1'b0;
        bc_d      = 1'b0;
        br_d      = 1'b0;
        rowb_we_d = 1'b0;
        // fetch the old row for the x move
        occ_re    = 1'b1;
        occ_raddr = ROW_W'(ld_r1);
        state_d   = ST_XAX;
      end

      ST_XAX: begin
        c1n_d     = c1_q;
        rowa_d    = occ_rd_q;
        r2_d      = r2y;
        pysum_d   = POS_W'(ysum);
        bprod_d   = bm_prod;
        // fetch the target row for the y move
        occ_re    = 1'b1;
        occ_raddr = ROW_W'(r2y);
        if (!col_on(c2)) begin
          bc_d = 1'b1;
        end else if (c2 == c1_q) begin
          px_d = POS_W'(xsum);
        end else if (row_on(r1_q) && occ_rd_q[COL_W'(c2)]) begin
          bc_d = 1'b1;
        end else begin
          px_d   = POS_W'(xsum);
          c1n_d  = c2;
          mc_d   = 1'b1;
          rowa_d = row_x;
          if (row_on(r1_q)) begin
            occ_we    = 1'b1;
            occ_waddr = ROW_W'(r1_q);
            occ_wdata = row_x;
          end
        end
        state_d = ST_YAX;
      end

      ST_YAX: begin
        if (bc_q) begin
          sx_d = bounce_v;
        end
        bprod_d = bm_prod;
        if (!row_on(r2_q)) begin
          br_d = 1'b1;
        end else if (r2_q == r1_q) begin
          py_d = pysum_q;
        end else if (col_on(c1n_q) && occ_rd_q[COL_W'(c1n_q)]) begin
          br_d = 1'b1;
        end else begin
          py_d      = pysum_q;
          mr_d      = 1'b1;
          rowb_d    = row_b;
          rowb_we_d = col_on(c1n_q);
          // clear the old pixel now, set the new one during write back
          if (row_on(r1_q) && col_on(c1n_q)) begin
            occ_we    = 1'b1;
            occ_waddr = ROW_W'(r1_q);
            occ_wdata = row_y;
          end
        end
        state_d = ST_WB;
      end

      ST_WB: begin
        pm_we    = 1'b1;
        pm_waddr = pid_q;
        pm_wdata = '{px: px_q, py: py_q, sx: sx_q, sy: (br_q ? bounce_v : sy_q)};
        if (rowb_we_q) begin
          occ_we    = 1'b1;
          occ_waddr = ROW_W'(r2_q);
          occ_wdata = rowb_q;
        end
        res_oc_d  = c1_q[5:0];
        res_or_d  = r1_q[6:0];
        res_nc_d  = c1n_q[5:0];
        res_nr_d  = mr_q ? r2_q[6:0] : r1_q[6:0];
        res_mc_d  = mc_q;
        res_mr_d  = mr_q;
        res_bc_d  = bc_q;
        res_br_d  = br_q;
        res_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
      ref_x_q   <= '0;
      ref_y_q   <= '0;
      gain_q    <= GAIN_INIT;
      elast_q   <= ELAST_INIT;
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      ref_x_q   <= ref_x_d;
      ref_y_q   <= ref_y_d;
      gain_q    <= gain_d;
      elast_q   <= elast_d;
      acc_x_q   <= acc_x_d;
      acc_y_q   <= acc_y_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_x_q   <= smp_x_d;
    smp_y_q   <= smp_y_d;
    pid_q     <= pid_d;
    nz_x_q    <= nz_x_d;
    nz_y_q    <= nz_y_d;
    pcol_q    <= pcol_d;
    prow_q    <= prow_d;
    pset_q    <= pset_d;
    pix_ok_q  <= pix_ok_d;
    px_q      <= px_d;
    py_q      <= py_d;
    pysum_q   <= pysum_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    c1_q      <= c1_d;
    r1_q      <= r1_d;
    c1n_q     <= c1n_d;
    r2_q      <= r2_d;
    rowa_q    <= rowa_d;
    rowb_q    <= rowb_d;
    rowb_we_q <= rowb_we_d;
    bprod_q   <= bprod_d;
    mc_q      <= mc_d;
    mr_q      <= mr_d;
    bc_q      <= bc_d;
    br_q      <= br_d;
    res_oc_q  <= res_oc_d;
    res_or_q  <= res_or_d;
    res_nc_q  <= res_nc_d;
    res_nr_q  <= res_nr_d;
    res_mc_q  <= res_mc_d;
    res_mr_q  <= res_mr_d;
    res_bc_q  <= res_bc_d;
    res_br_q  <= res_br_d;
    res_pv_q  <= res_pv_d;
  end

  // particle memory
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rd_q <= pm_mem[PIDX_W'(particle_i)];
    end
  end

  // occupancy memory, one row of pixels per entry
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (occ_re) begin
      occ_rd_q <= occ_mem[occ_raddr];
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_vld_q;
  assign old_col_o      = res_oc_q;
  assign old_row_o      = res_or_q;
  assign new_col_o      = res_nc_q;
  assign new_row_o      = res_nr_q;
  assign moved_col_o    = res_mc_q;
  assign moved_row_o    = res_mr_q;
  assign bounced_col_o  = res_bc_q;
  assign bounced_row_o  = res_br_q;
  assign pixel_value_o  = res_pv_q;

`ifndef SYNTHESIS
  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (state_q == ST_IDLE))
    else $error("result strobe outside idle");

  a_wb_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |=> res_vld_q)
    else $error("write back without result");

  a_move_xor_bounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |-> (!(mc_q && bc_q) && !(mr_q && br_q)))
    else $error("axis both moved and bounced");

  a_no_occ_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !occ_we && !pm_we)
    else $error("memory write while idle");
`endif

endmodule

`default_nettype wire
